// ===== design/pfa_pkg.sv =====
// Package for the page frame free-list allocator: defaults, codes, state type.
`timescale 1ns / 1ps

package pfa_pkg;

   localparam int NumFramesDefault  = 128;
   localparam int MaxRunDefault     = 64;
   localparam int FrameShiftDefault = 21;

   localparam int FuncWidth   = 2;
   localparam int CountWidth  = 8;
   localparam int FrameWidth  = 7;
   localparam int AddrWidth   = 28;
   localparam int StatusWidth = 3;

   localparam logic [FuncWidth-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FuncWidth-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FuncWidth-1:0] FUNC_INIT  = 2'd2;

   localparam logic [StatusWidth-1:0] STATUS_OK         = 3'd0;
   localparam logic [StatusWidth-1:0] STATUS_ZERO       = 3'd1;
   localparam logic [StatusWidth-1:0] STATUS_NOT_ENOUGH = 3'd2;
   localparam logic [StatusWidth-1:0] STATUS_TOO_LARGE  = 3'd3;
   localparam logic [StatusWidth-1:0] STATUS_OVERFLOW   = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_EMIT
   } pfa_state_type;

endpackage

// ===== design/page_frame_free_list_allocator.sv =====
// Page frame allocator: free list kept as a stack of frame indices in one memory.
`timescale 1ns / 1ps

// Usage:
//  req_ channel carries one request: tuser = func, tdata = count and frame.
//  rsp_ channel carries one result: tuser = status, tdata = frame index and
//  its physical address, tlast on the final result of a request.
//  Initialize sweeps the stack memory, one entry a cycle, and accepts no
//  request meanwhile; it returns no result.
//  Allocate of n frames pops them all or none. Each frame is one memory
//  read (ST_READ) then a move into the output register (ST_EMIT), which
//  waits while a stalled receiver holds that register. Errors give one result
//  in the cycle after the request.
//  Free items are one memory write each; only a run that would
//  overflow the list gives a result, on its first item.
//  Reset empties the list (free count 0); the stack memory holds garbage
//  until the first initialize or free writes it.
//  A stalled receiver holds the output register; requests are still taken
//  while the result waits, as long as the register drains in that cycle.
module page_frame_free_list_allocator #(
   parameter int NUM_FRAMES  = pfa_pkg::NumFramesDefault,
   parameter int MAX_RUN     = pfa_pkg::MaxRunDefault,
   parameter int FRAME_SHIFT = pfa_pkg::FrameShiftDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // count [7:0], frame [14:8], zero [15]
   input  logic [pfa_pkg::FuncWidth-1:0] req_tuser,   // func [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // frame_res [6:0], frame_addr [34:7], zero [39:35]
   output logic [pfa_pkg::StatusWidth-1:0] rsp_tuser, // status [2:0]
   output logic        rsp_tlast
);
   import pfa_pkg::*;

   localparam int AW = $clog2(NUM_FRAMES);
   localparam int TW = $clog2(NUM_FRAMES + 1);
   localparam int SW = ((TW > CountWidth) ? TW : CountWidth) + 1;

   pfa_state_type state_ff, state_in;

   logic [TW-1:0]         free_total_ff, free_total_in;
   logic [CountWidth-1:0] run_pos_ff, run_pos_in;
   logic                  run_rej_ff, run_rej_in;
   logic [TW-1:0]         base_ff, base_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [CountWidth-1:0] k_ff, k_in;
   logic [AW-1:0]         init_idx_ff, init_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FrameWidth-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [FrameWidth-1:0] stack_mem [NUM_FRAMES];
   logic [FrameWidth-1:0] rd_data_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [FrameWidth-1:0] wr_data;

   logic [FuncWidth-1:0]  req_func;
   logic [CountWidth-1:0] req_count;
   logic [FrameWidth-1:0] req_frame;
   logic                  req_fire;
   logic                  slot_free;
   logic                  alloc_ok;
   logic                  emit_last;

   logic [CountWidth-1:0] run_len;
   logic [SW-1:0]         run_sum;
   logic [SW-1:0]         run_idx;
   logic                  run_overflow;
   logic                  run_ends;
   logic                  rej_now;

   assign req_func  = req_tuser;
   assign req_count = req_tdata[7:0];
   assign req_frame = req_tdata[14:8];

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire = req_tvalid && req_tready;

   assign alloc_ok = (req_count != '0) && (req_count <= CountWidth'(MAX_RUN)) &&
                     (SW'(req_count) <= SW'(free_total_ff));
   assign emit_last = (CountWidth'(k_ff + 1'b1) == cnt_ff);

   // free run arithmetic; a zero count means a run of one
   assign run_len      = (req_count == '0) ? CountWidth'(1) : req_count;
   assign run_sum      = SW'(free_total_ff) + SW'(run_len);
   assign run_idx      = run_sum - SW'(1) - SW'(run_pos_ff);
   assign run_overflow = run_sum > SW'(NUM_FRAMES);
   assign run_ends     = (SW'(run_pos_ff) + SW'(1)) >= SW'(run_len);
   assign rej_now      = (run_pos_ff == '0) ? run_overflow : run_rej_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_func == FUNC_INIT) begin
                  state_in = ST_INIT;
               end else if (req_func == FUNC_ALLOC && alloc_ok) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_INIT: begin
            if (init_idx_ff == AW'(NUM_FRAMES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = emit_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      free_total_in = free_total_ff;
      run_pos_in    = run_pos_ff;
      run_rej_in    = run_rej_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      init_idx_in   = init_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rd_en         = 1'b0;
      rd_addr       = AW'(base_ff + TW'(k_ff));
      wr_en         = 1'b0;
      wr_addr       = run_idx[AW-1:0];
      wr_data       = req_frame;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_INIT: begin
                     run_pos_in    = '0;
                     run_rej_in    = 1'b0;
                     free_total_in = TW'(NUM_FRAMES);
                     init_idx_in   = '0;
                  end
                  FUNC_ALLOC: begin
                     run_pos_in = '0;
                     run_rej_in = 1'b0;
                     if (alloc_ok) begin
                        base_in       = free_total_ff - TW'(req_count);
                        free_total_in = free_total_ff - TW'(req_count);
                        cnt_in        = req_count;
                        k_in          = '0;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_frame_in = '0;
                        rsp_last_in  = 1'b1;
                        if (req_count == '0) begin
                           rsp_status_in = STATUS_ZERO;
                        end else if (req_count > CountWidth'(MAX_RUN)) begin
                           rsp_status_in = STATUS_TOO_LARGE;
                        end else begin
                           rsp_status_in = STATUS_NOT_ENOUGH;
                        end
                     end
                  end
                  FUNC_FREE: begin
                     if (run_pos_ff == '0 && run_overflow) begin
                        rsp_valid_in  = 1'b1;
                        rsp_frame_in  = '0;
                        rsp_status_in = STATUS_OVERFLOW;
                        rsp_last_in   = 1'b1;
                     end
                     if (!rej_now) begin
                        // entries past the end of the stack are dropped
                        wr_en = (run_pos_ff < run_len) && (run_idx < SW'(NUM_FRAMES));
                        if (run_ends) begin
                           free_total_in = run_overflow ? TW'(NUM_FRAMES) : TW'(run_sum);
                        end
                     end
                     if (run_ends) begin
                        run_pos_in = '0;
                        run_rej_in = 1'b0;
                     end else begin
                        run_pos_in = CountWidth'(run_pos_ff + 1'b1);
                        run_rej_in = rej_now;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = init_idx_ff;
            wr_data     = FrameWidth'(init_idx_ff);
            init_idx_in = AW'(init_idx_ff + 1'b1);
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = rd_data_ff;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = emit_last;
               k_in          = CountWidth'(k_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_total_ff <= '0;
         run_pos_ff    <= '0;
         run_rej_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_total_ff <= free_total_in;
         run_pos_ff    <= run_pos_in;
         run_rej_ff    <= run_rej_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      init_idx_ff   <= init_idx_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, AddrWidth'(AddrWidth'(rsp_frame_ff) << FRAME_SHIFT),
                        rsp_frame_ff};

endmodule

// ===== dv/page_frame_free_list_allocator_tb.sv =====
// Self-checking testbench for the page frame free-list allocator.
`timescale 1ns / 1ps

typedef struct packed {
   logic [pfa_pkg::FrameWidth-1:0]  frame_res;
   logic [pfa_pkg::AddrWidth-1:0]   frame_addr;
   logic [pfa_pkg::StatusWidth-1:0] status;
   logic                            last;
} frame_grant_t;

class frame_list_scoreboard;
   localparam int Frames    = pfa_pkg::NumFramesDefault;
   localparam int MaxRun    = pfa_pkg::MaxRunDefault;
   localparam int AddrShift = pfa_pkg::FrameShiftDefault;

   logic [pfa_pkg::FrameWidth-1:0] stack_mem [Frames];
   int unsigned free_total;
   int unsigned run_pos;
   bit          run_dropped;
   frame_grant_t grants_q [$];
   int unsigned errors;

   function new();
      free_total  = 0;
      run_pos     = 0;
      run_dropped = 0;
      errors      = 0;
   endfunction

   function void push_grant(int unsigned frame, logic [2:0] status, bit last);
      frame_grant_t g;
      g.frame_res  = frame[pfa_pkg::FrameWidth-1:0];
      g.frame_addr = pfa_pkg::AddrWidth'(frame << AddrShift);
      g.status     = status;
      g.last       = last;
      grants_q.push_back(g);
   endfunction

   function void note_request(logic [1:0] func, logic [7:0] count, logic [6:0] frame);
      int unsigned len;
      int unsigned base;
      int unsigned idx;
      bit          ends;
      case (func)
         pfa_pkg::FUNC_INIT: begin
            for (int i = 0; i < Frames; i++) stack_mem[i] = i[6:0];
            free_total  = Frames;
            run_pos     = 0;
            run_dropped = 0;
         end
         pfa_pkg::FUNC_ALLOC: begin
            run_pos     = 0;
            run_dropped = 0;
            if (count == 0) begin
               push_grant(0, pfa_pkg::STATUS_ZERO, 1);
            end else if (count > MaxRun) begin
               push_grant(0, pfa_pkg::STATUS_TOO_LARGE, 1);
            end else if (count > free_total) begin
               push_grant(0, pfa_pkg::STATUS_NOT_ENOUGH, 1);
            end else begin
               base = free_total - count;
               // deepest entry first
               for (int unsigned k = 0; k < count; k++) begin
                  idx = base + k;
                  push_grant((idx < Frames) ? stack_mem[idx] : 0, pfa_pkg::STATUS_OK,
                             k + 1 == count);
               end
               free_total = base;
            end
         end
         pfa_pkg::FUNC_FREE: begin
            len = (count == 0) ? 1 : count;
            if (run_pos == 0) begin
               run_dropped = (free_total + len > Frames);
               if (run_dropped) push_grant(0, pfa_pkg::STATUS_OVERFLOW, 1);
            end
            ends = (run_pos + 1 >= len);
            if (!run_dropped) begin
               if (run_pos < len) begin
                  // first item of the run lands on top
                  idx = free_total + len - 1 - run_pos;
                  if (idx < Frames) stack_mem[idx] = frame;
               end
               if (ends) free_total = (free_total + len > Frames) ? Frames : free_total + len;
            end
            if (ends) begin
               run_pos     = 0;
               run_dropped = 0;
            end else begin
               run_pos++;
            end
         end
         default: ;
      endcase
   endfunction

   function void check_result(frame_grant_t got);
      frame_grant_t want;
      if (grants_q.size() == 0) begin
         $error("result with none pending: frame_res=%0d status=%0d", got.frame_res,
                got.status);
         errors++;
         return;
      end
      want = grants_q.pop_front();
      if (got.frame_res !== want.frame_res) begin
         $error("frame_res expected %0d actual %0d", want.frame_res, got.frame_res);
         errors++;
      end
      if (got.frame_addr !== want.frame_addr) begin
         $error("frame_addr expected 0x%0h actual 0x%0h", want.frame_addr, got.frame_addr);
         errors++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last expected %0d actual %0d", want.last, got.last);
         errors++;
      end
   endfunction
endclass

module page_frame_free_list_allocator_tb;
   import pfa_pkg::*;

   localparam logic [FuncWidth-1:0] FUNC_UNUSED = 2'd3;
   localparam int          NumFrames   = NumFramesDefault;
   localparam int unsigned CycleLimit  = 3000000;
   localparam int unsigned RandomItems = 300;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [FuncWidth-1:0] req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic [StatusWidth-1:0] rsp_tuser;
   logic        rsp_tlast;

   frame_list_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned stall_left = 0;
   bit          req_steady = 0;
   bit          rsp_steady = 0;

   page_frame_free_list_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      r = $urandom_range(99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // result side: check accepted results, then choose the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tdata[6:0], rsp_tdata[34:7], rsp_tuser, rsp_tlast});
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 0;
      end else begin
         stall_left = pick_gap(rsp_steady);
         rsp_tready <= (stall_left == 0);
      end
   end

   task automatic send_request(input logic [1:0] func, input int unsigned count,
                               input int unsigned frame);
      int unsigned idle;
      idle = pick_gap(req_steady);
      if (idle > 0) begin
         req_tvalid <= 0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {1'b0, frame[6:0], count[7:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, count[7:0], frame[6:0]);
      if (func != FUNC_UNUSED) items_sent++;
   endtask

   task automatic send_free_run(input int unsigned count, input int unsigned items);
      for (int unsigned i = 0; i < items; i++) begin
         // ignored function in the middle of a run leaves the run intact
         if ($urandom_range(19) == 0) send_request(FUNC_UNUSED, $urandom_range(255),
                                                   $urandom_range(127));
         send_request(FUNC_FREE, count, $urandom_range(127));
      end
   endtask

   function automatic int unsigned pick_alloc_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6) return 0;
      if (r < 12) return $urandom_range(65, 128);
      if (r < 20) return $urandom_range(9, 64);
      if (r < 26) return (sb.free_total < 64) ? sb.free_total + 1 : 64;
      return $urandom_range(1, 8);
   endfunction

   task automatic random_free();
      int unsigned avail;
      int unsigned len;
      int unsigned items;
      avail = NumFrames - sb.free_total;
      if (avail < NumFrames && (avail == 0 || $urandom_range(99) < 8)) begin
         // overflowing run: first item flagged, the rest ignored, then abandon it
         len = $urandom_range(avail + 1, NumFrames);
         send_free_run(len, (len > 1) ? $urandom_range(1, 2) : 1);
         send_request(FUNC_ALLOC, pick_alloc_count(), $urandom_range(127));
         return;
      end
      if (avail > 8 && $urandom_range(99) < 6) len = $urandom_range(9, avail);
      else len = $urandom_range(0, (avail < 8) ? avail : 8);
      items = (len == 0) ? 1 : len;
      if (items > 1 && $urandom_range(9) == 0) begin
         send_free_run(len, $urandom_range(1, items - 1));
         send_request(FUNC_ALLOC, pick_alloc_count(), $urandom_range(127));
      end else begin
         send_free_run(len, items);
      end
   endtask

   initial begin
      int unsigned start_items;
      int unsigned r;
      repeat (4) @(posedge clock);
      reset <= 0;

      // empty list after reset: error checks in priority order
      send_request(FUNC_ALLOC, 0, 0);
      send_request(FUNC_ALLOC, 65, 127);
      send_request(FUNC_ALLOC, 128, 0);
      send_request(FUNC_ALLOC, 1, 0);
      send_request(FUNC_UNUSED, 255, 127);
      // two-frame run, first item on top
      send_request(FUNC_FREE, 2, 127);
      send_request(FUNC_FREE, 2, 0);
      send_request(FUNC_ALLOC, 2, 0);
      // zero-length run counts as one frame
      send_request(FUNC_FREE, 0, 85);
      send_request(FUNC_ALLOC, 1, 42);
      send_request(FUNC_INIT, 0, 0);
      send_request(FUNC_FREE, 1, 5);
      send_request(FUNC_ALLOC, 64, 0);
      send_request(FUNC_ALLOC, 64, 127);
      send_request(FUNC_ALLOC, 1, 0);
      // run cut short by an allocate
      send_request(FUNC_FREE, 3, 1);
      send_request(FUNC_FREE, 3, 2);
      send_request(FUNC_ALLOC, 1, 0);
      // overflow on a full list, rest of run ignored
      send_request(FUNC_INIT, 128, 127);
      send_request(FUNC_FREE, 128, 127);
      send_request(FUNC_FREE, 128, 3);
      send_request(FUNC_ALLOC, 0, 0);
      send_request(FUNC_INIT, 0, 0);

      start_items = items_sent;
      while (items_sent - start_items < RandomItems) begin
         if ($urandom_range(29) == 0) begin
            req_steady = $urandom_range(2) == 0;
            rsp_steady = $urandom_range(2) == 0;
         end
         r = $urandom_range(99);
         if (r < 3) send_request(FUNC_INIT, $urandom_range(128), $urandom_range(127));
         else if (r < 45) send_request(FUNC_ALLOC, pick_alloc_count(), $urandom_range(127));
         else if (r < 92) random_free();
         else send_request(FUNC_UNUSED, $urandom_range(255), $urandom_range(127));
      end
      // drop valid at the edge that took the last request
      req_tvalid <= 0;

      while (sb.grants_q.size() != 0) @(posedge clock);
      repeat (3 * NumFrames) @(posedge clock);
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// ===== sim.f =====
design/pfa_pkg.sv
design/page_frame_free_list_allocator.sv
dv/page_frame_free_list_allocator_tb.sv
